// ===== rtl/assert_macros.svh =====
// Assertion macros used by the tape pulse generator engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TPG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TPG_ASSERT_NEVER(lbl, clk, rst, prop, msg) \
   `TPG_ASSERT(lbl, clk, rst, !(prop), msg)
`else
`define TPG_ASSERT(lbl, clk, rst, prop, msg)
`define TPG_ASSERT_NEVER(lbl, clk, rst, prop, msg)
`endif
`endif

// ===== rtl/tpg_pkg.sv =====
// Types, constants and helper functions of the tape pulse generator.
package tpg_pkg;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   localparam logic [14:0] LEAD_COUNT      = 15'd6000;
   localparam logic [7:0]  K_LEAD          = 8'd142;
   localparam logic [7:0]  K_SYNC1         = 8'd43;
   localparam logic [7:0]  K_SYNC2         = 8'd48;
   localparam logic [7:0]  K_ONE           = 8'd112;
   localparam logic [7:0]  K_ZERO          = 8'd56;
   localparam logic [4:0]  HALVES_PER_BYTE = 5'd16;
   localparam logic [8:0]  NO_LOAD         = 9'd256;
   localparam logic [1:0]  SPEED_MAX       = 2'd2;

   localparam logic [2:0] PHASE_CODE_LEAD  = 3'd0;
   localparam logic [2:0] PHASE_CODE_SYNC1 = 3'd1;
   localparam logic [2:0] PHASE_CODE_SYNC2 = 3'd2;
   localparam logic [2:0] PHASE_CODE_DATA  = 3'd3;
   localparam logic [2:0] PHASE_CODE_STOP  = 3'd4;

   typedef enum logic [4:0] {
      PH_LEAD  = 5'b00001,
      PH_SYNC1 = 5'b00010,
      PH_SYNC2 = 5'b00100,
      PH_DATA  = 5'b01000,
      PH_STOP  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic        command;
      logic [15:0] block_length;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic        tape_level;
      logic [8:0]  half_period;
      logic [2:0]  phase;
      logic [15:0] byte_address;
      logic [15:0] bytes_sent;
   } rsp_type;

   function automatic logic [8:0] scale_half(input logic [7:0] k, input logic [1:0] s);
      return {1'b0, k >> s} + 9'd1;
   endfunction

   function automatic logic [2:0] phase_code(input phase_type p);
      logic [2:0] code;
      case (p)
         PH_LEAD:  code = PHASE_CODE_LEAD;
         PH_SYNC1: code = PHASE_CODE_SYNC1;
         PH_SYNC2: code = PHASE_CODE_SYNC2;
         PH_DATA:  code = PHASE_CODE_DATA;
         default:  code = PHASE_CODE_STOP;
      endcase
      return code;
   endfunction

endpackage

// ===== rtl/tpg_in_reg.sv =====
// Input register that holds one request until the engine takes it.
module tpg_in_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  tpg_pkg::req_type req_data,
   input  logic             advance,
   output logic             hold_valid,
   output tpg_pkg::req_type hold_data
);
   import tpg_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   assign req_tready = !valid_ff || advance;
   assign valid_in   = req_tvalid ? 1'b1 : (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         data_ff <= req_data;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_data  = data_ff;
endmodule

// ===== rtl/tpg_engine.sv =====
// Waveform state and the single-pass update for one request.
`include "assert_macros.svh"
module tpg_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_wr_data,
   input  logic             advance,
   input  tpg_pkg::req_type req,
   output tpg_pkg::rsp_type rsp
);
   import tpg_pkg::*;

   logic [1:0]  speed_ff;
   logic [1:0]  speed_eff;
   phase_type   phase_ff, phase_in;
   logic        level_ff, level_in;
   logic [14:0] lead_ff, lead_in;
   logic [4:0]  hidx_ff, hidx_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] size_ff, size_in;
   logic [15:0] sent_ff, sent_in;
   logic [8:0]  half;
   logic        level_out;
   logic        need_byte;
   logic [7:0]  bit_byte;
   logic [4:0]  hidx_cur;

   assign speed_eff = (speed_ff > SPEED_MAX) ? SPEED_MAX : speed_ff;
   assign need_byte = (hidx_ff >= HALVES_PER_BYTE);
   assign bit_byte  = need_byte ? req.data_byte : shift_ff;
   assign hidx_cur  = need_byte ? 5'd0 : hidx_ff;

   always_comb begin
      phase_in  = phase_ff;
      level_in  = level_ff;
      lead_in   = lead_ff;
      hidx_in   = hidx_ff;
      shift_in  = shift_ff;
      addr_in   = addr_ff;
      size_in   = size_ff;
      sent_in   = sent_ff;
      half      = NO_LOAD;
      level_out = 1'b0;
      if (req.command == CMD_START) begin
         size_in  = req.block_length;
         lead_in  = LEAD_COUNT << speed_eff;
         phase_in = PH_LEAD;
         level_in = 1'b0;
         sent_in  = 16'd0;
      end else begin
         case (phase_ff)
            PH_LEAD: begin
               level_out = level_ff;
               level_in  = ~level_ff;
               half      = scale_half(K_LEAD, speed_eff);
               if (lead_ff != 15'd0) begin
                  lead_in = lead_ff - 15'd1;
               end else begin
                  phase_in = PH_SYNC1;
               end
            end
            PH_SYNC1: begin
               level_out = level_ff;
               level_in  = ~level_ff;
               half      = scale_half(K_SYNC1, speed_eff);
               phase_in  = PH_SYNC2;
            end
            PH_SYNC2: begin
               level_out = level_ff;
               level_in  = ~level_ff;
               half      = scale_half(K_SYNC2, speed_eff);
               phase_in  = PH_DATA;
               hidx_in   = HALVES_PER_BYTE;
               shift_in  = 8'd0;
               addr_in   = 16'd0;
            end
            PH_DATA: begin
               level_out = level_ff;
               level_in  = ~level_ff;
               if (need_byte && (addr_ff >= size_ff)) begin
                  phase_in = PH_STOP;
                  sent_in  = 16'd0;
               end else begin
                  if (need_byte) begin
                     addr_in = addr_ff + 16'd1;
                     sent_in = addr_ff + 16'd1;
                  end
                  half     = bit_byte[7] ? scale_half(K_ONE, speed_eff)
                                         : scale_half(K_ZERO, speed_eff);
                  shift_in = hidx_cur[0] ? {bit_byte[6:0], 1'b0} : bit_byte;
                  hidx_in  = hidx_cur + 5'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp.tape_level   = level_out;
   assign rsp.half_period  = half;
   assign rsp.phase        = phase_code(phase_in);
   assign rsp.byte_address = addr_in;
   assign rsp.bytes_sent   = sent_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= 2'd0;
      end else if (csr_wr_en) begin
         speed_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STOP;
         level_ff <= 1'b0;
         lead_ff  <= 15'd0;
         hidx_ff  <= 5'd0;
         shift_ff <= 8'd0;
         addr_ff  <= 16'd0;
         size_ff  <= 16'd0;
         sent_ff  <= 16'd0;
      end else if (advance) begin
         phase_ff <= phase_in;
         level_ff <= level_in;
         lead_ff  <= lead_in;
         hidx_ff  <= hidx_in;
         shift_ff <= shift_in;
         addr_ff  <= addr_in;
         size_ff  <= size_in;
         sent_ff  <= sent_in;
      end
   end

   `TPG_ASSERT(a_hidx_range, clock, reset, (phase_ff == PH_DATA) |-> (hidx_ff <= HALVES_PER_BYTE), "bit index past byte end")
   `TPG_ASSERT(a_addr_bound, clock, reset, (phase_ff == PH_DATA) |-> (addr_ff <= size_ff), "fetch address beyond block size")
   `TPG_ASSERT(a_sent_match, clock, reset, (phase_ff == PH_DATA) |-> (sent_ff == addr_ff), "sent count differs from fetch address")
   `TPG_ASSERT_NEVER(a_lead_max, clock, reset, lead_ff > (LEAD_COUNT << SPEED_MAX), "lead count too large")
endmodule

// ===== rtl/tpg_out_reg.sv =====
// Result register between the engine and the response channel.
module tpg_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  tpg_pkg::rsp_type rsp_data,
   output logic             out_free,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output tpg_pkg::rsp_type rsp_hold
);
   import tpg_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign out_free = !valid_ff || rsp_tready;
   assign valid_in = load ? 1'b1 : (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_hold   = data_ff;
endmodule

// ===== rtl/tape_pulse_generator.sv =====
// Top level of the cassette tape half-period generator.
//
//   Channel  Direction  Payload
//   req      in         tdata: block_length, data_byte; tuser: command
//   rsp      out        tdata: tape_level, half_period, phase, byte_address, bytes_sent
//   csr      in         wr_data: speed
//
// A request is registered on acceptance and processed when the engine advances.
// A tick request's response is registered in the result register; a start yields none.
// The single-pass update sustains one request per cycle while no response is stalled.
// Reset is synchronous and puts the block into the stop phase at normal speed.
// A stalled response holds the result register, and new requests wait only when it is full.
module tape_pulse_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // block_length[15:0], data_byte[23:16]
   input  logic        req_tuser,   // command[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // tape_level[0], half_period[9:1], phase[12:10],
                                    // byte_address[28:13], bytes_sent[44:29], zero[47:45]
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);
   import tpg_pkg::*;

   req_type req_data;
   req_type hold_data;
   rsp_type rsp_next;
   rsp_type rsp_hold;
   logic    hold_valid;
   logic    out_free;
   logic    advance;
   logic    out_load;

   assign req_data.command      = req_tuser;
   assign req_data.block_length = req_tdata[15:0];
   assign req_data.data_byte    = req_tdata[23:16];

   assign advance  = hold_valid && ((hold_data.command == CMD_START) || out_free);
   assign out_load = advance && (hold_data.command == CMD_TICK);

   tpg_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_data   (req_data),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_data  (hold_data)
   );

   tpg_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .advance     (advance),
      .req         (hold_data),
      .rsp         (rsp_next)
   );

   tpg_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .rsp_data   (rsp_next),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_hold   (rsp_hold)
   );

   assign rsp_tdata = {3'b000, rsp_hold.bytes_sent, rsp_hold.byte_address, rsp_hold.phase,
                       rsp_hold.half_period, rsp_hold.tape_level};
endmodule
